// ===== rtl/core/ssr_pkg.sv =====
// shared types, constants and lookup functions for the seven-segment rectangle renderer
package ssr_pkg;

   localparam logic [7:0] SCREEN_W = 8'd128;
   localparam logic [7:0] SCREEN_H = 8'd160;

   localparam logic [7:0] SECOND_SLOT_OFFSET_RESET = 8'd63;

   // command queue between front and back
   localparam int CMD_FIFO_DEPTH = 4;
   localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);

   localparam logic REQ_DRAW  = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   // segment indexes, bit 0 = G up to bit 6 = A
   localparam logic [2:0] SEG_G = 3'd0;
   localparam logic [2:0] SEG_F = 3'd1;
   localparam logic [2:0] SEG_E = 3'd2;
   localparam logic [2:0] SEG_D = 3'd3;
   localparam logic [2:0] SEG_C = 3'd4;
   localparam logic [2:0] SEG_B = 3'd5;
   localparam logic [2:0] SEG_A = 3'd6;

   typedef struct packed {
      logic [7:0] x0;
      logic [7:0] x1;
      logic [7:0] y0;
      logic [7:0] y1;
   } rect_type;

   typedef struct packed {
      logic        is_clear;
      logic [6:0]  mask;
      logic [6:0]  pattern;
      logic [15:0] fg_color;
      logic [15:0] bg_color;
      logic [7:0]  x_offset;
   } cmd_type;

   function automatic logic [6:0] digit_pattern(input logic [3:0] digit);
      logic [6:0] pat;
      unique case (digit)
         4'd0: pat = 7'h7E;
         4'd1: pat = 7'h30;
         4'd2: pat = 7'h6D;
         4'd3: pat = 7'h79;
         4'd4: pat = 7'h33;
         4'd5: pat = 7'h5B;
         4'd6: pat = 7'h5F;
         4'd7: pat = 7'h70;
         4'd8: pat = 7'h7F;
         4'd9: pat = 7'h7B;
         default: pat = 7'h00;
      endcase
      return pat;
   endfunction

   function automatic rect_type seg_rect(input logic [2:0] idx);
      rect_type r;
      unique case (idx)
         SEG_G: r = '{x0: 8'd13, x1: 8'd53, y0: 8'd60,  y1: 8'd70};
         SEG_F: r = '{x0: 8'd3,  x1: 8'd13, y0: 8'd20,  y1: 8'd60};
         SEG_E: r = '{x0: 8'd3,  x1: 8'd13, y0: 8'd71,  y1: 8'd110};
         SEG_D: r = '{x0: 8'd13, x1: 8'd53, y0: 8'd110, y1: 8'd120};
         SEG_C: r = '{x0: 8'd53, x1: 8'd63, y0: 8'd70,  y1: 8'd110};
         SEG_B: r = '{x0: 8'd53, x1: 8'd63, y0: 8'd20,  y1: 8'd60};
         default: r = '{x0: 8'd13, x1: 8'd53, y0: 8'd10, y1: 8'd20};
      endcase
      return r;
   endfunction

   // lowest set bit picks segment G first
   function automatic logic [2:0] lowest_bit(input logic [6:0] m);
      logic [2:0] idx;
      idx = SEG_G;
      for (int i = 6; i >= 0; i--) begin
         if (m[i]) begin
            idx = 3'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== rtl/core/ssr_if.sv =====
// request and response channel interfaces
interface ssr_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [3:0]  digit;
   logic        slot;
   logic [15:0] color;

   modport source (output valid, req_type, digit, slot, color, input ready);
   modport sink   (input valid, req_type, digit, slot, color, output ready);
endinterface

interface ssr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  x_start;
   logic [7:0]  x_end;
   logic [7:0]  y_start;
   logic [7:0]  y_end;
   logic [15:0] fill_color;
   logic        last;

   modport source (output valid, x_start, x_end, y_start, y_end, fill_color, last,
                   input ready);
   modport sink   (input valid, x_start, x_end, y_start, y_end, fill_color, last,
                   output ready);
endinterface

// ===== rtl/core/ssr_front.sv =====
// front end: takes requests, tracks background and slot patterns, issues commands
module ssr_front (
   input  logic               clock,
   input  logic               reset,
   ssr_req_if.sink            req_chan,
   input  logic               csr_we,
   input  logic [7:0]         csr_wdata,
   output logic               push,
   output ssr_pkg::cmd_type   push_cmd,
   input  logic               fifo_full
);

   logic [15:0] bg_ff, bg_in;
   logic [6:0]  pat0_ff, pat0_in;
   logic [6:0]  pat1_ff, pat1_in;
   logic [7:0]  offset_ff, offset_in;

   logic        accept;
   logic [6:0]  new_pat;
   logic [6:0]  old_pat;
   logic [6:0]  mask;

   assign req_chan.ready = !fifo_full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      new_pat = ssr_pkg::digit_pattern(req_chan.digit);
      old_pat = req_chan.slot ? pat1_ff : pat0_ff;
      // empty slot draws every lit segment, otherwise only the differences
      mask    = (old_pat == 7'd0) ? new_pat : (new_pat ^ old_pat);

      push_cmd.is_clear = (req_chan.req_type == ssr_pkg::REQ_CLEAR);
      push_cmd.mask     = mask;
      push_cmd.pattern  = new_pat;
      push_cmd.fg_color = req_chan.color;
      push_cmd.bg_color = bg_ff;
      push_cmd.x_offset = req_chan.slot ? offset_ff : 8'd0;

      if (req_chan.req_type == ssr_pkg::REQ_CLEAR) begin
         push = accept && (req_chan.color != bg_ff);
      end else begin
         push = accept && (mask != 7'd0);
      end

      bg_in     = bg_ff;
      pat0_in   = pat0_ff;
      pat1_in   = pat1_ff;
      offset_in = csr_we ? csr_wdata : offset_ff;
      if (accept) begin
         if (req_chan.req_type == ssr_pkg::REQ_CLEAR) begin
            if (req_chan.color != bg_ff) begin
               bg_in   = req_chan.color;
               pat0_in = 7'd0;
               pat1_in = 7'd0;
            end
         end else if (req_chan.slot) begin
            pat1_in = new_pat;
         end else begin
            pat0_in = new_pat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff     <= 16'd0;
         pat0_ff   <= 7'd0;
         pat1_ff   <= 7'd0;
         offset_ff <= ssr_pkg::SECOND_SLOT_OFFSET_RESET;
      end else begin
         bg_ff     <= bg_in;
         pat0_ff   <= pat0_in;
         pat1_ff   <= pat1_in;
         offset_ff <= offset_in;
      end
   end

   a_push_has_work: assert property (@(posedge clock) disable iff (reset)
      push && !push_cmd.is_clear |-> push_cmd.mask != 7'd0)
      else $error("draw command queued with nothing to draw");

endmodule

// ===== rtl/core/ssr_cmd_fifo.sv =====
// short command queue between front and back
module ssr_cmd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ssr_pkg::cmd_type   push_cmd,
   output logic               full,
   input  logic               pop,
   output ssr_pkg::cmd_type   pop_cmd,
   output logic               not_empty
);

   ssr_pkg::cmd_type                entries_ff [ssr_pkg::CMD_FIFO_DEPTH];
   logic [ssr_pkg::CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ssr_pkg::CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ssr_pkg::CMD_PTR_W:0]     count_ff, count_in;

   assign full      = (count_ff == (ssr_pkg::CMD_PTR_W+1)'(ssr_pkg::CMD_FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("command pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("command popped from empty queue");

endmodule

// ===== rtl/core/ssr_back.sv =====
// back end: walks command segment masks; one rectangle per cycle unless stalled
module ssr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  ssr_pkg::cmd_type   cmd,
   output logic               pop,
   ssr_rsp_if.source          rsp_chan
);

   ssr_pkg::cmd_type cmd_ff, cmd_in;
   logic [6:0]       rem_ff, rem_in;
   logic             busy_ff, busy_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       x_start_ff, x_start_in;
   logic [7:0]       x_end_ff, x_end_in;
   logic [7:0]       y_start_ff, y_start_in;
   logic [7:0]       y_end_ff, y_end_in;
   logic [15:0]      fill_ff, fill_in;
   logic             last_ff, last_in;

   logic             advance;
   logic             emit;
   logic [2:0]       idx;
   logic [6:0]       pick;
   logic             is_last;
   ssr_pkg::rect_type rect;

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign emit    = advance && busy_ff;

   always_comb begin
      idx     = ssr_pkg::lowest_bit(rem_ff);
      pick    = 7'd1 << idx;
      is_last = ((rem_ff & ~pick) == 7'd0);
      rect    = ssr_pkg::seg_rect(idx);

      // refill as the current command hands over its final rectangle
      pop = cmd_valid && (!busy_ff || (emit && is_last));

      cmd_in  = cmd_ff;
      rem_in  = rem_ff;
      busy_in = busy_ff;
      if (pop) begin
         cmd_in  = cmd;
         rem_in  = cmd.is_clear ? 7'd1 : cmd.mask;
         busy_in = 1'b1;
      end else if (emit && is_last) begin
         busy_in = 1'b0;
      end else if (emit) begin
         rem_in = rem_ff & ~pick;
      end

      rsp_valid_in = rsp_valid_ff;
      x_start_in   = x_start_ff;
      x_end_in     = x_end_ff;
      y_start_in   = y_start_ff;
      y_end_in     = y_end_ff;
      fill_in      = fill_ff;
      last_in      = last_ff;
      if (advance) begin
         rsp_valid_in = busy_ff;
         if (cmd_ff.is_clear) begin
            x_start_in = 8'd0;
            x_end_in   = ssr_pkg::SCREEN_W;
            y_start_in = 8'd0;
            y_end_in   = ssr_pkg::SCREEN_H;
            fill_in    = cmd_ff.fg_color;
         end else begin
            // column sums wrap at 8 bits
            x_start_in = rect.x0 + cmd_ff.x_offset;
            x_end_in   = rect.x1 + cmd_ff.x_offset;
            y_start_in = rect.y0;
            y_end_in   = rect.y1;
            fill_in    = cmd_ff.pattern[idx] ? cmd_ff.fg_color : cmd_ff.bg_color;
         end
         last_in = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      rem_ff     <= rem_in;
      x_start_ff <= x_start_in;
      x_end_ff   <= x_end_in;
      y_start_ff <= y_start_in;
      y_end_ff   <= y_end_in;
      fill_ff    <= fill_in;
      last_ff    <= last_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.x_start    = x_start_ff;
   assign rsp_chan.x_end      = x_end_ff;
   assign rsp_chan.y_start    = y_start_ff;
   assign rsp_chan.y_end      = y_end_ff;
   assign rsp_chan.fill_color = fill_ff;
   assign rsp_chan.last       = last_ff;

   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff != 7'd0)
      else $error("back end busy with empty segment mask");

   a_emit_shows_word: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted rectangle did not reach the output register");

   a_mask_shrinks: assert property (@(posedge clock) disable iff (reset)
      emit && !is_last |=> busy_ff && ($countones(rem_ff) == $countones($past(rem_ff)) - 1))
      else $error("segment mask did not drop exactly one bit");

endmodule

// ===== rtl/core/seven_segment_rect_renderer.sv =====
// top level of the seven-segment rectangle renderer
// Each request word turns into zero to seven rectangle words on the response channel,
// delivered at one rectangle per clock unless the response channel stalls: a draw gives
// one word per changed (or, on an empty slot, lit) segment in the order G, F, E, D, C, B,
// A, a clear to a new colour gives one full-screen word, and the final word of a request
// carries last. The front end updates background and slot patterns and accepts one
// request per cycle while its four-entry command queue has room; requests that draw
// nothing are accepted but never enter the queue. The back end walks one queued command
// at a time through its segment mask, so the sustained rate is set by the back end. The
// response is registered: an accepted request passes the queue entry and the back end's
// command register before its first word reaches the response register.
// Write csr_wdata with csr_we only while idle.
module seven_segment_rect_renderer (
   input  logic        clock,
   input  logic        reset,
   ssr_req_if.sink     req_chan,
   ssr_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   logic             push;
   ssr_pkg::cmd_type push_cmd;
   logic             fifo_full;
   logic             pop;
   ssr_pkg::cmd_type pop_cmd;
   logic             fifo_not_empty;

   ssr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .push      (push),
      .push_cmd  (push_cmd),
      .fifo_full (fifo_full)
   );

   ssr_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (fifo_full),
      .pop       (pop),
      .pop_cmd   (pop_cmd),
      .not_empty (fifo_not_empty)
   );

   ssr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (fifo_not_empty),
      .cmd       (pop_cmd),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== tb/seven_segment_rect_renderer_test.sv =====
// self-checking testbench for the seven-segment rectangle renderer with a built-in predictor
module seven_segment_rect_renderer_test;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int RANDOM_PER_PHASE = 48;

   // digit 9 down to digit 0, bit 6 = A ... bit 0 = G
   localparam logic [9:0][6:0] DIGIT_SEGMENTS = {
      7'h7B, 7'h7F, 7'h70, 7'h5F, 7'h5B, 7'h33, 7'h79, 7'h6D, 7'h30, 7'h7E
   };

   // {x0, x1, y0, y1} per segment, A down to G
   localparam logic [6:0][31:0] SEG_BOX = {
      {8'd13, 8'd53, 8'd10,  8'd20},
      {8'd53, 8'd63, 8'd20,  8'd60},
      {8'd53, 8'd63, 8'd70,  8'd110},
      {8'd13, 8'd53, 8'd110, 8'd120},
      {8'd3,  8'd13, 8'd71,  8'd110},
      {8'd3,  8'd13, 8'd20,  8'd60},
      {8'd13, 8'd53, 8'd60,  8'd70}
   };

   typedef struct packed {
      logic        req_type;
      logic [3:0]  digit;
      logic        slot;
      logic [15:0] color;
   } panel_request_type;

   typedef struct packed {
      logic [7:0]  x_start;
      logic [7:0]  x_end;
      logic [7:0]  y_start;
      logic [7:0]  y_end;
      logic [15:0] fill_color;
      logic        last;
   } rect_word_type;

   typedef enum logic [1:0] {FLOW_FREE, FLOW_COIN, FLOW_PATTERN} flow_mode_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [7:0] csr_wdata;

   ssr_req_if req_chan ();
   ssr_rsp_if rsp_chan ();

   seven_segment_rect_renderer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [15:0] model_background;
   logic [6:0]  model_pattern [2];
   logic [7:0]  model_offset;

   panel_request_type request_queue [$];
   rect_word_type     expected_rects [$];
   panel_request_type accepted_req;
   logic [15:0]       recent_clear_color = 16'h0000;

   int errors          = 0;
   int cycle_count     = 0;
   int items_accepted  = 0;
   int clears_painted  = 0;
   int rects_checked   = 0;
   int offsets_written = 0;

   int burst_left = 4;
   int gap_left   = 0;

   flow_mode_type flow_mode     = FLOW_FREE;
   logic [7:0]    stall_pattern = 8'hFF;
   int            flow_run      = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // works out the rectangles one request paints and updates the panel state
   task automatic render_request(input panel_request_type r);
      logic [6:0] new_pat;
      logic [6:0] old_pat;
      logic [7:0] off;
      logic [31:0] box;
      rect_word_type w;
      rect_word_type batch [$];
      if (r.req_type == ssr_pkg::REQ_CLEAR) begin
         if (r.color != model_background) begin
            w = '{x_start: 8'd0, x_end: ssr_pkg::SCREEN_W, y_start: 8'd0,
                  y_end: ssr_pkg::SCREEN_H, fill_color: r.color, last: 1'b1};
            expected_rects.push_back(w);
            model_background = r.color;
            model_pattern[0] = 7'h00;
            model_pattern[1] = 7'h00;
            clears_painted++;
         end
      end else begin
         new_pat = (r.digit < 4'd10) ? DIGIT_SEGMENTS[r.digit] : 7'h00;
         old_pat = model_pattern[r.slot];
         off = r.slot ? model_offset : 8'd0;
         for (int s = 0; s < 7; s++) begin
            // an empty slot paints lit segments only, a drawn one paints differences
            if ((old_pat == 7'h00) ? new_pat[s] : (new_pat[s] != old_pat[s])) begin
               box = SEG_BOX[s];
               w.x_start = off + box[31:24];
               w.x_end = off + box[23:16];
               w.y_start = box[15:8];
               w.y_end = box[7:0];
               w.fill_color = new_pat[s] ? r.color : model_background;
               w.last = 1'b0;
               batch.push_back(w);
            end
         end
         if (batch.size() > 0) begin
            batch[batch.size() - 1].last = 1'b1;
         end
         foreach (batch[i]) begin
            expected_rects.push_back(batch[i]);
         end
         model_pattern[r.slot] = new_pat;
      end
   endtask

   task automatic add_request(input logic kind, input logic [3:0] digit, input logic slot,
                              input logic [15:0] color);
      panel_request_type r;
      r = '{req_type: kind, digit: digit, slot: slot, color: color};
      request_queue.push_back(r);
   endtask

   function automatic panel_request_type random_request();
      panel_request_type r;
      r.req_type = ($urandom_range(0, 9) == 0) ? ssr_pkg::REQ_CLEAR : ssr_pkg::REQ_DRAW;
      r.digit = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(10, 15))
                                            : 4'($urandom_range(0, 9));
      r.slot = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: r.color = 16'h0000;
         1: r.color = 16'hFFFF;
         2: r.color = recent_clear_color;
         default: r.color = 16'($urandom);
      endcase
      if (r.req_type == ssr_pkg::REQ_CLEAR) begin
         recent_clear_color = r.color;
      end
      return r;
   endfunction

   // sender stops here until every word has come back and the block has settled
   task automatic wait_for_idle();
      while (request_queue.size() != 0 || req_chan.valid || expected_rects.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_offset(input logic [7:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      model_offset = value;
      offsets_written++;
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // request driver: bursts of words with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            accepted_req.req_type = req_chan.req_type;
            accepted_req.digit = req_chan.digit;
            accepted_req.slot = req_chan.slot;
            accepted_req.color = req_chan.color;
            render_request(accepted_req);
            items_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (request_queue.size() > 0) begin
               accepted_req = request_queue.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.req_type <= accepted_req.req_type;
               req_chan.digit <= accepted_req.digit;
               req_chan.slot <= accepted_req.slot;
               req_chan.color <= accepted_req.color;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response backpressure
   always @(posedge clock) begin
      if (flow_run == 0) begin
         flow_mode = flow_mode_type'($urandom_range(0, 2));
         stall_pattern = 8'($urandom) | 8'h01;
         flow_run = $urandom_range(20, 120);
      end
      flow_run--;
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      case (flow_mode)
         FLOW_FREE: rsp_chan.ready <= 1'b1;
         FLOW_COIN: rsp_chan.ready <= 1'($urandom_range(0, 1));
         default: rsp_chan.ready <= stall_pattern[0];
      endcase
   end

   // response checker
   always @(posedge clock) begin
      rect_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rects.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual x %0d..%0d y %0d..%0d %h %b",
                     $time, rsp_chan.x_start, rsp_chan.x_end, rsp_chan.y_start,
                     rsp_chan.y_end, rsp_chan.fill_color, rsp_chan.last);
            errors++;
         end else begin
            want = expected_rects.pop_front();
            check_field("x_start", 16'(want.x_start), 16'(rsp_chan.x_start));
            check_field("x_end", 16'(want.x_end), 16'(rsp_chan.x_end));
            check_field("y_start", 16'(want.y_start), 16'(rsp_chan.y_start));
            check_field("y_end", 16'(want.y_end), 16'(rsp_chan.y_end));
            check_field("fill_color", want.fill_color, rsp_chan.fill_color);
            check_field("last", 16'(want.last), 16'(rsp_chan.last));
            rects_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words still expected", $time, expected_rects.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [7:0] offsets [5];
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 8'd0;
      req_chan.valid = 1'b0;
      req_chan.req_type = ssr_pkg::REQ_DRAW;
      req_chan.digit = 4'd0;
      req_chan.slot = 1'b0;
      req_chan.color = 16'h0000;
      rsp_chan.ready = 1'b0;
      model_background = 16'h0000;
      model_pattern[0] = 7'h00;
      model_pattern[1] = 7'h00;
      model_offset = ssr_pkg::SECOND_SLOT_OFFSET_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: full digit on empty slot, unchanged, partial changes, blanks, clears
      add_request(ssr_pkg::REQ_DRAW, 4'd8, 1'b0, 16'hFFFF);
      add_request(ssr_pkg::REQ_DRAW, 4'd8, 1'b0, 16'h1234);
      add_request(ssr_pkg::REQ_DRAW, 4'd1, 1'b0, 16'hA5A5);
      add_request(ssr_pkg::REQ_DRAW, 4'd10, 1'b0, 16'h5A5A);
      add_request(ssr_pkg::REQ_DRAW, 4'd15, 1'b1, 16'h0005);
      add_request(ssr_pkg::REQ_DRAW, 4'd0, 1'b1, 16'h8001);
      add_request(ssr_pkg::REQ_CLEAR, 4'd0, 1'b0, 16'h0000);
      add_request(ssr_pkg::REQ_CLEAR, 4'd15, 1'b1, 16'hFFFF);
      add_request(ssr_pkg::REQ_CLEAR, 4'd0, 1'b0, 16'hFFFF);
      for (int d = 2; d < 10; d++) begin
         add_request(ssr_pkg::REQ_DRAW, 4'(d), 1'(d), 16'(d * 16'h1111));
      end
      add_request(ssr_pkg::REQ_CLEAR, 4'd3, 1'b1, 16'h0000);
      add_request(ssr_pkg::REQ_DRAW, 4'd7, 1'b1, 16'hFFFF);
      add_request(ssr_pkg::REQ_DRAW, 4'd4, 1'b1, 16'h0000);
      add_request(ssr_pkg::REQ_DRAW, 4'd12, 1'b1, 16'h7FFF);
      wait_for_idle();

      offsets = '{8'd0, 8'd192, 8'd255, 8'($urandom), 8'd1};
      foreach (offsets[p]) begin
         write_offset(offsets[p]);
         repeat (RANDOM_PER_PHASE) request_queue.push_back(random_request());
         wait_for_idle();
      end

      $display("run covered %0d requests (%0d screen clears) and %0d checked rectangles",
               items_accepted, clears_painted, rects_checked);
      $display("slot one offset set %0d times, wrap past column 255 included", offsets_written);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/ssr_pkg.sv
rtl/core/ssr_if.sv
rtl/core/ssr_front.sv
rtl/core/ssr_cmd_fifo.sv
rtl/core/ssr_back.sv
rtl/core/seven_segment_rect_renderer.sv
tb/seven_segment_rect_renderer_test.sv
